// ===== src/dip_pkg.sv =====
// Shared types and constants for the decimal integer stream parser.
// No dependencies; imported by dip_core and decimal_integer_stream_parser_top.
package dip_pkg;

    // Fixed field widths
    localparam int VALUE_W   = 32;
    localparam int TIMEOUT_W = 24;
    localparam int BYTE_W    = 8;

    // Timeout register value after reset
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd2000000;

    // ASCII codes and number base
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam int unsigned       DEC_BASE = 10;

    // Input beat kind
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } dip_op_t;

    // Why a number ended
    typedef enum logic {
        CAUSE_BYTE    = 1'b0,
        CAUSE_TIMEOUT = 1'b1
    } dip_cause_t;

    // Parser phase
    typedef enum logic {
        PH_SKIP  = 1'b0,
        PH_DIGIT = 1'b1
    } dip_phase_t;

    // One registered input beat
    typedef struct packed {
        dip_op_t           op;
        logic [BYTE_W-1:0] data;
    } dip_beat_t;

    // Result flags from one parser step
    typedef struct packed {
        logic       fire;
        dip_cause_t cause;
    } dip_result_t;

endpackage

// ===== src/decimal_integer_stream_parser_top.sv =====
// Top level of the decimal integer stream parser: beat and result registers,
// timeout register and handshake. Depends on dip_pkg and dip_core.
//
//  channel | signals                        | direction | beat
//  --------+--------------------------------+-----------+------------------------
//  in      | in_valid, in_stall             | in        | operation, rx_byte
//  out     | out_valid, out_stall           | out       | value, end_cause
//  cfg     | cfg_we, cfg_wdata              | in        | timeout in ticks
//
// One beat per cycle sustained while out_stall does not hold a result; a taken beat
// goes from the beat register through one parser update into the result register.
// Reset (rst_n low) clears the parser to the skip phase and timeout to 2000000.
// in_stall rises only while a beat waits and the result register is held by out_stall.
module decimal_integer_stream_parser_top
    import dip_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int TIMER_BITS = 24
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [TIMEOUT_W-1:0]      cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      operation,
    input  logic [BYTE_W-1:0]         rx_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [VALUE_W-1:0] value,
    output logic                      end_cause
);

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic                 beat_valid_reg;
    dip_beat_t            beat_reg;
    logic                 out_valid_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic                 out_cause_reg;

    logic                 advance;
    logic                 accept_in;
    logic                 step_en;
    dip_result_t          step_result;
    logic [VALUE_W-1:0]   step_value;

    // Handshake: result register free or draining lets the beat stage move
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = beat_valid_reg && !advance;
    assign accept_in = in_valid && !in_stall;
    assign step_en   = beat_valid_reg && advance;

    // Timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= TIMEOUT_RESET;
        else if (cfg_we)
            timeout_reg <= cfg_wdata;
    end

    // Input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_valid_reg <= 1'b0;
        else if (accept_in)
            beat_valid_reg <= 1'b1;
        else if (advance)
            beat_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            beat_reg.op   <= dip_op_t'(operation);
            beat_reg.data <= rx_byte;
        end
    end

    // Parser
    dip_core #(
        .VALUE_BITS (VALUE_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .beat         (beat_reg),
        .timeout      (timeout_reg),
        .result       (step_result),
        .result_value (step_value)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= step_en && step_result.fire;
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_en && step_result.fire)
        begin
            out_value_reg <= step_value;
            out_cause_reg <= step_result.cause;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = $signed(out_value_reg);
    assign end_cause = out_cause_reg;

    // Input stalls only when the result register is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("in_stall without a held result");

    // A fresh result comes only from a parser step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg && out_stall)) |-> $past(step_en))
        else $error("result without a parser step");

    // A beat waiting with a free output always steps
    a_beat_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_valid_reg && !out_valid_reg) |-> step_en)
        else $error("beat stuck with free result register");

endmodule

// ===== src/dip_core.sv =====
// Parser state (phase, sign, accumulator, tick timer) and its one-step update.
// Depends on dip_pkg.
module dip_core
    import dip_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int TIMER_BITS = 24
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  dip_beat_t            beat,
    input  logic [TIMEOUT_W-1:0] timeout,
    output dip_result_t          result,
    output logic [VALUE_W-1:0]   result_value
);

    localparam int CmpW = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
    localparam int OutW = (VALUE_BITS > VALUE_W) ? VALUE_BITS : VALUE_W;

    dip_phase_t              phase_reg, phase_next;
    logic                    neg_reg, neg_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic [TIMER_BITS-1:0]   elapsed_reg, elapsed_next;

    logic                    is_digit;
    logic                    is_minus;
    logic [BYTE_W-1:0]       digit_full;
    logic [VALUE_BITS-1:0]   digit_val;
    logic [VALUE_BITS-1:0]   acc_x10;
    logic [VALUE_BITS-1:0]   emit_val;
    logic [OutW-1:0]         emit_ext;
    logic [CmpW-1:0]         tmo_ext;
    logic [CmpW-1:0]         tmax_ext;
    logic [CmpW-1:0]         eff_ext;
    logic [TIMER_BITS-1:0]   eff_timeout;
    logic [TIMER_BITS-1:0]   elapsed_inc;
    logic                    timed_out;

    // Byte classification
    assign is_digit   = (beat.data >= CH_ZERO) && (beat.data <= CH_NINE);
    assign is_minus   = (beat.data == CH_MINUS);
    assign digit_full = beat.data - CH_ZERO;
    assign digit_val  = VALUE_BITS'(digit_full[3:0]);

    // Accumulate one decimal digit, wrapping at VALUE_BITS
    assign acc_x10 = VALUE_BITS'(acc_reg * VALUE_BITS'(DEC_BASE)) + digit_val;

    // Signed value of the number so far
    assign emit_val     = neg_reg ? (~acc_reg + VALUE_BITS'(1)) : acc_reg;
    assign emit_ext     = OutW'(emit_val);
    assign result_value = emit_ext[VALUE_W-1:0];

    // Effective timeout: zero acts as one, clamp to the timer range
    assign tmo_ext  = CmpW'(timeout);
    assign tmax_ext = CmpW'({TIMER_BITS{1'b1}});
    always_comb
    begin
        if (tmo_ext == '0)
            eff_ext = CmpW'(1);
        else if (tmo_ext > tmax_ext)
            eff_ext = tmax_ext;
        else
            eff_ext = tmo_ext;
    end
    assign eff_timeout = eff_ext[TIMER_BITS-1:0];

    // Saturating tick count
    assign elapsed_inc = (elapsed_reg != {TIMER_BITS{1'b1}}) ?
                         (elapsed_reg + TIMER_BITS'(1)) : elapsed_reg;
    assign timed_out   = (elapsed_inc >= eff_timeout);

    // Next state and result for the beat at hand
    always_comb
    begin
        phase_next   = phase_reg;
        neg_next     = neg_reg;
        acc_next     = acc_reg;
        elapsed_next = elapsed_reg;
        result.fire  = 1'b0;
        result.cause = CAUSE_BYTE;
        case (beat.op)
            OP_TICK:
            begin
                elapsed_next = elapsed_inc;
                if (timed_out)
                begin
                    if (phase_reg == PH_SKIP)
                    begin
                        // skip phase ran out: open the digit phase anyway
                        phase_next   = PH_DIGIT;
                        elapsed_next = '0;
                    end
                    else
                    begin
                        result.fire  = 1'b1;
                        result.cause = CAUSE_TIMEOUT;
                        phase_next   = PH_SKIP;
                        neg_next     = 1'b0;
                        acc_next     = '0;
                        elapsed_next = '0;
                    end
                end
            end
            OP_BYTE:
            begin
                if (phase_reg == PH_SKIP)
                begin
                    if (is_minus)
                    begin
                        neg_next     = 1'b1;
                        phase_next   = PH_DIGIT;
                        elapsed_next = '0;
                    end
                    else if (is_digit)
                    begin
                        acc_next     = digit_val;
                        phase_next   = PH_DIGIT;
                        elapsed_next = '0;
                    end
                end
                else if (is_digit)
                begin
                    acc_next     = acc_x10;
                    elapsed_next = '0;
                end
                else
                begin
                    // terminator ends the number and opens the next parse
                    result.fire  = 1'b1;
                    result.cause = CAUSE_BYTE;
                    phase_next   = is_minus ? PH_DIGIT : PH_SKIP;
                    neg_next     = is_minus;
                    acc_next     = '0;
                    elapsed_next = '0;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SKIP;
            neg_reg     <= 1'b0;
            acc_reg     <= '0;
            elapsed_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            neg_reg     <= neg_next;
            acc_reg     <= acc_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule
